// ----- rtl/oota_pkg.sv -----
// Package for the overcurrent/overtemperature alarm: state, operation and register codes.
`default_nettype none
package oota_pkg;

  // Protection states, one-hot
  typedef enum logic [4:0] {
    ST_INIT     = 5'b00001,
    ST_NORMAL   = 5'b00010,
    ST_WARNING  = 5'b00100,
    ST_CRITICAL = 5'b01000,
    ST_SAFE     = 5'b10000
  } alarm_state_e;

  // Reported state codes
  localparam logic [2:0] CODE_INIT     = 3'd0;
  localparam logic [2:0] CODE_NORMAL   = 3'd1;
  localparam logic [2:0] CODE_WARNING  = 3'd2;
  localparam logic [2:0] CODE_CRITICAL = 3'd3;
  localparam logic [2:0] CODE_SAFE     = 3'd4;

  // Item operations
  typedef enum logic [1:0] {
    OP_EVAL         = 2'd0,
    OP_INIT_RESULT  = 2'd1,
    OP_MANUAL_RESET = 2'd2
  } op_e;

  // Configuration register indexes (byte address / 4)
  localparam int unsigned ADDR_W = 5;
  localparam logic [2:0] REG_CUR_CRIT  = 3'd0;
  localparam logic [2:0] REG_CUR_WARN  = 3'd1;
  localparam logic [2:0] REG_CUR_HYST  = 3'd2;
  localparam logic [2:0] REG_TEMP_CRIT = 3'd3;
  localparam logic [2:0] REG_TEMP_WARN = 3'd4;
  localparam logic [2:0] REG_TEMP_HYST = 3'd5;

  // Reset values of the limits
  localparam logic signed [15:0] CUR_CRIT_RST  = 16'sd10000;
  localparam logic signed [15:0] CUR_WARN_RST  = 16'sd8000;
  localparam logic        [14:0] CUR_HYST_RST  = 15'd500;
  localparam logic signed [15:0] TEMP_CRIT_RST = 16'sd1360;
  localparam logic signed [15:0] TEMP_WARN_RST = 16'sd1120;
  localparam logic        [14:0] TEMP_HYST_RST = 15'd80;

  function automatic logic [2:0] state_code(alarm_state_e st);
    logic [2:0] code;
    unique case (st)
      ST_INIT:     code = CODE_INIT;
      ST_NORMAL:   code = CODE_NORMAL;
      ST_WARNING:  code = CODE_WARNING;
      ST_CRITICAL: code = CODE_CRITICAL;
      ST_SAFE:     code = CODE_SAFE;
      default:     code = CODE_INIT;
    endcase
    return code;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/oota_in_if.sv -----
// Input channel of the alarm block: one event item per handshake.
`default_nettype none
interface oota_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  operation;
  logic               init_ok;
  logic signed [15:0] current_ma;
  logic signed [15:0] temp_chip;
  logic signed [15:0] temp_thermistor;

  modport source (
    output valid, operation, init_ok, current_ma, temp_chip, temp_thermistor,
    input  ready
  );
  modport sink (
    input  valid, operation, init_ok, current_ma, temp_chip, temp_thermistor,
    output ready
  );
endinterface
`default_nettype wire

// ----- rtl/oota_out_if.sv -----
// Result channel of the alarm block: state after each item and a change flag.
`default_nettype none
interface oota_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] system_state;
  logic       state_changed;

  modport source (
    output valid, system_state, state_changed,
    input  ready
  );
  modport sink (
    input  valid, system_state, state_changed,
    output ready
  );
endinterface
`default_nettype wire

// ----- rtl/overcurrent_overtemp_alarm_fsm_top.sv -----
// Overcurrent/overtemperature protection state machine with APB limit registers.
//
// Usage:
//   in_i carries one event item: a sample (current, chip and thermistor
//   temperature), an init result, or a manual reset. out_o returns one item per
//   event: the state after it (0 init .. 4 safe shutdown) and whether it changed.
//   Limits and hysteresis margins sit in six APB registers at byte addresses
//   0,4,..,20; they are to be written only while the block is idle, but the
//   block itself does not enforce this. pready is tied high.
// Pipeline / throughput:
//   An accepted item is held in the input register; when it advances, its result
//   is loaded into the result register and is on out_o from then on. One item per
//   cycle is sustained while out_o takes each result, since the state register
//   updates in the same cycle the compare and next-state logic evaluates the item.
// Reset:
//   rst_ni clears the pipeline, puts the machine in INIT and loads the default
//   limits (10000/8000/500 mA, 1360/1120/80 in 1/16 degC).
// Stall:
//   When out_o is not taken, the result holds; the input register may still
//   hold one more item, after which in_i.ready drops until the result drains.
`default_nettype none
module overcurrent_overtemp_alarm_fsm_top (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  oota_in_if.sink                         in_i,
  oota_out_if.source                      out_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [oota_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready
);
  import oota_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [15:0] cur_crit_q, cur_warn_q, temp_crit_q, temp_warn_q;
  logic        [14:0] cur_hyst_q, temp_hyst_q;
  logic               cfg_wr;
  logic        [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_crit_q  <= CUR_CRIT_RST;
      cur_warn_q  <= CUR_WARN_RST;
      cur_hyst_q  <= CUR_HYST_RST;
      temp_crit_q <= TEMP_CRIT_RST;
      temp_warn_q <= TEMP_WARN_RST;
      temp_hyst_q <= TEMP_HYST_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CUR_CRIT:  cur_crit_q  <= pwdata[15:0];
        REG_CUR_WARN:  cur_warn_q  <= pwdata[15:0];
        REG_CUR_HYST:  cur_hyst_q  <= pwdata[14:0];
        REG_TEMP_CRIT: temp_crit_q <= pwdata[15:0];
        REG_TEMP_WARN: temp_warn_q <= pwdata[15:0];
        REG_TEMP_HYST: temp_hyst_q <= pwdata[14:0];
        default: ;  // unmapped: write dropped
      endcase
    end
  end

  // Readback, signed limits sign-extended
  always_comb begin
    unique case (cfg_idx)
      REG_CUR_CRIT:  prdata = {{16{cur_crit_q[15]}}, cur_crit_q};
      REG_CUR_WARN:  prdata = {{16{cur_warn_q[15]}}, cur_warn_q};
      REG_CUR_HYST:  prdata = {17'd0, cur_hyst_q};
      REG_TEMP_CRIT: prdata = {{16{temp_crit_q[15]}}, temp_crit_q};
      REG_TEMP_WARN: prdata = {{16{temp_warn_q[15]}}, temp_warn_q};
      REG_TEMP_HYST: prdata = {17'd0, temp_hyst_q};
      default:       prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic               s1_valid_q;
  logic        [1:0]  s1_op_q;
  logic               s1_init_ok_q;
  logic signed [15:0] s1_cur_q, s1_tchip_q, s1_ttherm_q;
  logic               out_valid_q;
  logic               s1_fire, in_fire;

  // The stage advances when the result register is empty or being drained
  assign s1_fire    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_fire;
  assign in_fire    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q      <= in_i.operation;
      s1_init_ok_q <= in_i.init_ok;
      s1_cur_q     <= in_i.current_ma;
      s1_tchip_q   <= in_i.temp_chip;
      s1_ttherm_q  <= in_i.temp_thermistor;
    end
  end

  // ---------------------------------------------------------------------------
  // Threshold compare and next state
  // ---------------------------------------------------------------------------
  alarm_state_e       state_q, state_d;
  logic signed [15:0] temp_max;
  logic signed [17:0] cur_clear_lim, temp_clear_lim;
  logic               is_crit, is_warn, is_clear;
  alarm_state_e       judged;

  assign temp_max = (s1_tchip_q > s1_ttherm_q) ? s1_tchip_q : s1_ttherm_q;

  // warning limit minus margin, exact in 18 bits
  assign cur_clear_lim  = $signed({{2{cur_warn_q[15]}}, cur_warn_q}) -
                          $signed({3'd0, cur_hyst_q});
  assign temp_clear_lim = $signed({{2{temp_warn_q[15]}}, temp_warn_q}) -
                          $signed({3'd0, temp_hyst_q});

  assign is_crit  = (s1_cur_q >= cur_crit_q) || (temp_max >= temp_crit_q);
  assign is_warn  = (s1_cur_q >= cur_warn_q) || (temp_max >= temp_warn_q);
  assign is_clear = ($signed({{2{s1_cur_q[15]}}, s1_cur_q}) < cur_clear_lim) &&
                    ($signed({{2{temp_max[15]}}, temp_max}) < temp_clear_lim);

  always_comb begin
    if (is_crit) begin
      judged = ST_CRITICAL;
    end else if (is_warn) begin
      judged = ST_WARNING;
    end else if (state_q == ST_WARNING && !is_clear) begin
      judged = ST_WARNING;  // hysteresis band holds the warning
    end else begin
      judged = ST_NORMAL;
    end
  end

  always_comb begin
    state_d = state_q;
    case (s1_op_q)
      OP_INIT_RESULT: state_d = s1_init_ok_q ? ST_NORMAL : ST_CRITICAL;
      OP_EVAL: begin
        unique case (state_q)
          ST_CRITICAL:           state_d = ST_SAFE;
          ST_NORMAL, ST_WARNING: state_d = judged;
          default:               state_d = state_q;  // INIT, SAFE ignore samples
        endcase
      end
      OP_MANUAL_RESET: begin
        if (state_q == ST_SAFE) begin
          state_d = ST_INIT;
        end
      end
      default: state_d = state_q;  // undefined operation: no change
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else if (s1_fire) begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic [2:0] res_state_q;
  logic       res_changed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      res_state_q   <= state_code(state_d);
      res_changed_q <= (state_d != state_q);
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.system_state  = res_state_q;
  assign out_o.state_changed = res_changed_q;

endmodule
`default_nettype wire
